// ===== hdl/asp_pkg.sv =====
// package with operation codes and search state machine type for the path search block
package asp_pkg;

	localparam logic [1:0] OP_EDGE = 2'd0;
	localparam logic [1:0] OP_HEUR = 2'd1;
	localparam logic [1:0] OP_RUN  = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_SCAN_END,
		ST_RELAX,
		ST_RELAX_END,
		ST_TRACE,
		ST_EMIT,
		ST_NOPATH
	} state_t;

endpackage

// ===== hdl/a_star_path_search.sv =====
// top level of the a-star shortest path search engine
// load items (edge weight, heuristic) are accepted back to back while idle and no result is pending
// a run initialises the vertex tables, then per closed vertex scans all vertices and relaxes its
// outgoing edges through the registered-read edge memory, then walks predecessors one per cycle and
// emits the path from start to goal, one item per buffer read, holding while m_tready is low
// arst_n clears control state and heuristics, then the clear state zeroes the edge memory
module a_star_path_search
	import asp_pkg::*;
#(
	parameter int NUM_VERTICES = 32,
	parameter int LENGTH_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,   // operation
	input  logic [31:0] s_tdata,   // from_vertex[4:0], to_vertex[9:5], value[25:10], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // path_vertex[4:0], status[5], zero pad
	output logic        m_tlast    // last
);

	localparam int VC  = (NUM_VERTICES < 32) ? NUM_VERTICES : 32;
	localparam int VB  = (VC > 1) ? $clog2(VC) : 1;
	localparam int CB  = LENGTH_BITS + 8;
	localparam int EN  = VC * VC;
	localparam int EB  = $clog2(EN);
	localparam logic [CB-1:0] C_UNR = {CB{1'b1}};
	localparam logic [CB-1:0] C_MAX = {{(CB-1){1'b1}}, 1'b0};
	localparam logic [VB:0]   VC_N  = (VB+1)'(VC);

	// input fields
	logic [4:0]             in_from, in_to;
	logic [15:0]            in_val;
	logic [LENGTH_BITS-1:0] in_len;
	assign in_from = s_tdata[4:0];
	assign in_to   = s_tdata[9:5];
	assign in_val  = s_tdata[25:10];
	assign in_len  = LENGTH_BITS'(in_val);

	logic in_acc;
	assign in_acc = s_tvalid && s_tready;
	logic from_ok, to_ok;
	assign from_ok = 32'(in_from) < VC;
	assign to_ok   = 32'(in_to) < VC;

	state_t state_q, state_d;

	// edge memory: present flag on top of the weight
	logic [LENGTH_BITS:0]   ew_mem [EN];
	logic [LENGTH_BITS:0]   ew_rd_q;
	logic                   ep_rd;
	logic [EB-1:0]          ew_waddr, e_raddr, clr_q;
	logic                   edge_wr;

	// vertex tables
	logic [LENGTH_BITS-1:0] heur_q [VC];
	logic [CB-1:0]          cost_q [VC];
	logic [5:0]             pred_q [VC];
	logic [VC-1:0]          closed_q;
	logic [4:0]             pbuf_mem [VC];

	logic [VB-1:0] start_q, goal_q, cur_q, idx_q, trace_q;
	logic [VB:0]   cnt_q, len_q;
	logic          found_q;
	logic [CB:0]   best_q;
	logic          rel_v_s1;
	logic [VB-1:0] rel_n_s1;
	logic [4:0]    pb_rd_q;
	logic          out_v_q, out_last_q, out_nop_q;
	logic [4:0]    out_vx_q;

	assign s_tready = (state_q == ST_IDLE) && !out_v_q;

	assign ew_waddr = EB'(in_from) * EB'(VC) + EB'(in_to);
	assign e_raddr  = EB'(cur_q) * EB'(VC) + EB'(idx_q);
	assign edge_wr  = in_acc && s_tuser == OP_EDGE && from_ok && to_ok;

	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR)
			ew_mem[clr_q] <= '0;
		else if (edge_wr)
			ew_mem[ew_waddr] <= {1'b1, in_len};
		ew_rd_q <= ew_mem[e_raddr];
	end

	assign ep_rd = ew_rd_q[LENGTH_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VC; i++)
				heur_q[i] <= '0;
		end else if (in_acc && s_tuser == OP_HEUR && from_ok) begin
			heur_q[VB'(in_from)] <= in_len;
		end
	end

	// scan priority
	logic [CB:0] pri;
	assign pri = {1'b0, cost_q[idx_q]} + (CB+1)'(heur_q[idx_q]);
	logic scan_ok;
	assign scan_ok = !closed_q[idx_q] && cost_q[idx_q] != C_UNR;

	// relax candidate
	logic [CB:0]   cand_w;
	logic [CB-1:0] cand;
	assign cand_w = {1'b0, cost_q[cur_q]} + (CB+1)'(ew_rd_q[LENGTH_BITS-1:0]);
	assign cand   = (cand_w > {1'b0, C_MAX}) ? C_MAX : cand_w[CB-1:0];

	logic last_idx;
	assign last_idx = idx_q == VB'(VC - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (clr_q == EB'(EN - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_acc && s_tuser == OP_RUN)
					state_d = (from_ok && to_ok) ? ST_INIT : ST_NOPATH;
			end
			ST_INIT:      if (last_idx) state_d = ST_SCAN;
			ST_SCAN:      if (last_idx) state_d = ST_SCAN_END;
			ST_SCAN_END: begin
				if (!found_q)           state_d = ST_NOPATH;
				else if (cur_q == goal_q) state_d = ST_TRACE;
				else                    state_d = ST_RELAX;
			end
			ST_RELAX:     if (last_idx) state_d = ST_RELAX_END;
			ST_RELAX_END: state_d = ST_SCAN;
			ST_TRACE: begin
				if (pred_q[trace_q] == 6'h3f || 32'(pred_q[trace_q]) >= VC
				    || len_q == VC_N - 1'b1)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if ((!out_v_q || m_tready) && len_q == '0 && cnt_q != '0)
					state_d = ST_IDLE;
			end
			ST_NOPATH:    if (!out_v_q || m_tready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	logic emit_go;
	assign emit_go = (state_q == ST_EMIT) && (!out_v_q || m_tready) && len_q != '0;

	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			cost_q[idx_q] <= (idx_q == start_q) ? '0 : C_UNR;
			pred_q[idx_q] <= 6'h3f;
		end
		if (rel_v_s1 && ep_rd && !closed_q[rel_n_s1] && cand < cost_q[rel_n_s1]) begin
			cost_q[rel_n_s1] <= cand;
			pred_q[rel_n_s1] <= 6'(cur_q);
		end
		if (state_q == ST_TRACE)
			pbuf_mem[len_q[VB-1:0]] <= 5'(trace_q);
		pb_rd_q <= pbuf_mem[VB'(len_q - (state_q == ST_EMIT ? 1'b1 : 1'b0))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			idx_q      <= '0;
			cnt_q      <= '0;
			len_q      <= '0;
			found_q    <= 1'b0;
			best_q     <= '0;
			cur_q      <= '0;
			start_q    <= '0;
			goal_q     <= '0;
			trace_q    <= '0;
			closed_q   <= '0;
			rel_v_s1   <= 1'b0;
			rel_n_s1   <= '0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
			out_nop_q  <= 1'b0;
			out_vx_q   <= '0;
		end else begin
			state_q  <= state_d;
			rel_v_s1 <= state_q == ST_RELAX;
			rel_n_s1 <= idx_q;
			if (out_v_q && m_tready)
				out_v_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					idx_q <= '0;
					if (in_acc && s_tuser == OP_RUN) begin
						start_q  <= VB'(in_from);
						goal_q   <= VB'(in_to);
						closed_q <= '0;
					end
				end
				ST_INIT: begin
					idx_q   <= last_idx ? '0 : idx_q + 1'b1;
					found_q <= 1'b0;
				end
				ST_SCAN: begin
					if (scan_ok && (!found_q || pri < best_q)) begin
						found_q <= 1'b1;
						best_q  <= pri;
						cur_q   <= idx_q;
					end
					idx_q <= last_idx ? '0 : idx_q + 1'b1;
				end
				ST_SCAN_END: begin
					idx_q   <= '0;
					trace_q <= goal_q;
					len_q   <= '0;
					cnt_q   <= '0;
				end
				ST_RELAX: idx_q <= last_idx ? '0 : idx_q + 1'b1;
				ST_RELAX_END: begin
					closed_q[cur_q] <= 1'b1;
					found_q <= 1'b0;
					idx_q   <= '0;
				end
				ST_TRACE: begin
					len_q <= len_q + 1'b1;
					if (!(pred_q[trace_q] == 6'h3f || 32'(pred_q[trace_q]) >= VC))
						trace_q <= VB'(pred_q[trace_q]);
				end
				ST_EMIT: begin
					// first the path buffer read, then one item each time the output slot is free
					if (cnt_q == '0) begin
						cnt_q <= 1'b1;
					end else if (emit_go) begin
						out_v_q    <= 1'b1;
						out_vx_q   <= pb_rd_q;
						out_nop_q  <= 1'b0;
						out_last_q <= len_q == 1'b1;
						len_q      <= len_q - 1'b1;
						cnt_q      <= '0;
					end
				end
				ST_NOPATH: begin
					if (!out_v_q || m_tready) begin
						out_v_q    <= 1'b1;
						out_vx_q   <= '0;
						out_nop_q  <= 1'b1;
						out_last_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b00, out_nop_q, out_vx_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input taken during a run");
	a_nop_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[5]) |-> m_tlast)
		else $error("no-path item without last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("result changed while stalled");
`endif

endmodule
